// ===== src/pphs_pkg.sv =====
// shared types and constants for the priority heap scheduler
package pphs_pkg;

  localparam int IdW    = 7;
  localparam int PrioW  = 8;
  localparam int BurstW = 16;
  localparam int OutTW  = 16;

  typedef enum logic [0:0] {
    OP_ARRIVAL = 1'b0,
    OP_TICK    = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_RAN     = 2'd1,
    ST_DONE    = 2'd2,
    ST_DROPPED = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t           opcode;
    logic [IdW-1:0]    task_id;
    logic [PrioW-1:0]  task_priority;
    logic [BurstW-1:0] burst_length;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [IdW-1:0]    ran_id;
    logic              first_run;
    logic [OutTW-1:0]  response_time;
    logic [OutTW-1:0]  wait_time;
  } out_item_t;

endpackage

// ===== src/pphs_heap_ram.sv =====
// heap slot memory, one write port and one registered read port
module pphs_heap_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/preemptive_priority_heap_scheduler.sv =====
// top level: heap sequencer sharing one priority comparator over a registered-read memory
// arrival: a parent read and a compare per sift-up level, then the slot is written
// tick: root read, last-slot fetch, left/right reads and compare per sift-down level, then
// the result and a reinsert if work remains; idle tick or drop: result the cycle after the beat
// one beat at a time; in_ready is low while the sequencer walks the heap memory
// reset (rst_n, synchronous) empties the heap and clears time; the memory is not cleared
module preemptive_priority_heap_scheduler #(
  parameter int HEAP_DEPTH = 128,
  parameter int TIME_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pphs_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pphs_pkg::out_item_t  out_data
);

  localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int TW = TIME_WIDTH;
  localparam int XW = AW + 2;
  localparam int BW = pphs_pkg::BurstW;
  localparam int OW = pphs_pkg::OutTW;

  typedef struct packed {
    logic [pphs_pkg::IdW-1:0]    id;
    logic [pphs_pkg::PrioW-1:0]  prio;
    logic [pphs_pkg::BurstW-1:0] remain;
    logic [pphs_pkg::BurstW-1:0] burst;
    logic [TW-1:0]               arrival;
    logic                        ran;
  } slot_t;

  localparam int SW = $bits(slot_t);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_UPRD  = 9'b000000010,
    S_UPCMP = 9'b000000100,
    S_RTRD  = 9'b000001000,
    S_RTWT  = 9'b000010000,
    S_DNL   = 9'b000100000,
    S_DNR   = 9'b001000000,
    S_DNCMP = 9'b010000000,
    S_RUN   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [TW-1:0] time_r, time_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] best_r, best_nxt;
  logic rc_ok_r, rc_ok_nxt;
  slot_t cur_r, cur_nxt;     // item being sifted
  slot_t bst_r, bst_nxt;     // best of current and left child
  slot_t run_r, run_nxt;     // task removed at the root
  logic out_valid_r, out_valid_nxt;
  pphs_pkg::out_item_t out_r, out_nxt;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  slot_t ram_wdata;
  logic [SW-1:0] ram_rdata;
  slot_t rdata;

  pphs_heap_ram #(.DEPTH(HEAP_DEPTH), .WIDTH(SW)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );
  assign rdata = slot_t'(ram_rdata);

  // shared comparator: a strictly below b
  logic [pphs_pkg::PrioW-1:0] cmp_a, cmp_b;
  logic cmp_lt;
  assign cmp_lt = cmp_a < cmp_b;

  // heap index arithmetic
  logic [XW-1:0] lchild, rchild;
  logic [AW-1:0] parent;
  assign lchild = XW'({pos_r, 1'b1});
  assign rchild = XW'({pos_r, 1'b0}) + XW'(2);
  assign parent = (pos_r - AW'(1)) >> 1;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // sequencer
  always_comb begin
    slot_t t;
    logic [CW-1:0] c1;
    state_nxt = state_r;
    count_nxt = count_r;
    time_nxt = time_r;
    pos_nxt = pos_r;
    best_nxt = best_r;
    rc_ok_nxt = rc_ok_r;
    cur_nxt = cur_r;
    bst_nxt = bst_r;
    run_nxt = run_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt = out_r;
    ram_we = 1'b0;
    ram_waddr = pos_r;
    ram_wdata = cur_r;
    ram_raddr = pos_r;
    cmp_a = cur_r.prio;
    cmp_b = rdata.prio;
    t = run_r;
    c1 = count_r - CW'(1);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          out_nxt = '0;
          if (in_data.opcode == pphs_pkg::OP_ARRIVAL) begin
            if (count_r >= CW'(HEAP_DEPTH)) begin
              out_nxt.status = pphs_pkg::ST_DROPPED;
              out_nxt.ran_id = in_data.task_id;
              out_valid_nxt = 1'b1;
            end else begin
              t.id = in_data.task_id;
              t.prio = in_data.task_priority;
              t.burst = (in_data.burst_length == '0) ? BW'(1) : in_data.burst_length;
              t.remain = t.burst;
              t.arrival = time_r;
              t.ran = 1'b0;
              cur_nxt = t;
              pos_nxt = count_r[AW-1:0];
              count_nxt = count_r + CW'(1);
              state_nxt = S_UPRD;
            end
          end else if (count_r == '0) begin
            out_nxt.status = pphs_pkg::ST_IDLE;
            out_valid_nxt = 1'b1;
            time_nxt = time_r + TW'(1);
          end else begin
            ram_raddr = '0;
            state_nxt = S_RTRD;
          end
        end
      end
      // sift-up: read parent of the hole, or settle at the root
      S_UPRD: begin
        if (pos_r == '0) begin
          ram_we = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ram_raddr = parent;
          best_nxt = parent;
          state_nxt = S_UPCMP;
        end
      end
      // parent moves down into the hole while strictly greater
      S_UPCMP: begin
        cmp_a = cur_r.prio;
        cmp_b = rdata.prio;
        ram_we = 1'b1;
        if (cmp_lt) begin
          ram_wdata = rdata;
          pos_nxt = best_r;
          state_nxt = S_UPRD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      // root taken, then fetch last slot
      S_RTRD: begin
        run_nxt = rdata;
        count_nxt = c1;
        if (c1 == '0) begin
          state_nxt = S_RUN;
        end else begin
          ram_raddr = c1[AW-1:0];
          state_nxt = S_RTWT;
        end
      end
      S_RTWT: begin
        cur_nxt = rdata;
        pos_nxt = '0;
        state_nxt = S_DNL;
      end
      // sift-down: read left child, or settle at a leaf
      S_DNL: begin
        if (lchild < XW'(count_r)) begin
          ram_raddr = lchild[AW-1:0];
          state_nxt = S_DNR;
        end else begin
          ram_we = 1'b1;
          state_nxt = S_RUN;
        end
      end
      // left against current, then read right child
      S_DNR: begin
        cmp_a = rdata.prio;
        cmp_b = cur_r.prio;
        if (cmp_lt) begin
          bst_nxt = rdata;
          best_nxt = lchild[AW-1:0];
        end else begin
          bst_nxt = cur_r;
          best_nxt = pos_r;
        end
        rc_ok_nxt = rchild < XW'(count_r);
        if (rchild < XW'(count_r)) ram_raddr = rchild[AW-1:0];
        state_nxt = S_DNCMP;
      end
      // right against the better, then move the winner up
      S_DNCMP: begin
        cmp_a = rdata.prio;
        cmp_b = bst_r.prio;
        ram_we = 1'b1;
        if (rc_ok_r && cmp_lt) begin
          ram_wdata = rdata;
          pos_nxt = rchild[AW-1:0];
          state_nxt = S_DNL;
        end else if (best_r != pos_r) begin
          ram_wdata = bst_r;
          pos_nxt = best_r;
          state_nxt = S_DNL;
        end else begin
          state_nxt = S_RUN;
        end
      end
      // run the task one unit and report
      S_RUN: begin
        out_nxt = '0;
        out_nxt.ran_id = t.id;
        if (!t.ran) begin
          out_nxt.first_run = 1'b1;
          out_nxt.response_time = OW'(time_r - t.arrival);
        end
        t.ran = 1'b1;
        t.remain = t.remain - BW'(1);
        if (t.remain != '0) begin
          out_nxt.status = pphs_pkg::ST_RAN;
          cur_nxt = t;
          pos_nxt = count_r[AW-1:0];
          count_nxt = count_r + CW'(1);
          state_nxt = S_UPRD;
        end else begin
          out_nxt.status = pphs_pkg::ST_DONE;
          out_nxt.wait_time = OW'(time_r + TW'(1) - t.arrival - TW'(t.burst));
          state_nxt = S_IDLE;
        end
        out_valid_nxt = 1'b1;
        time_nxt = time_r + TW'(1);
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      time_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      time_r <= time_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath and payload registers
  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    best_r <= best_nxt;
    rc_ok_r <= rc_ok_nxt;
    cur_r <= cur_nxt;
    bst_r <= bst_nxt;
    run_r <= run_nxt;
    out_r <= out_nxt;
  end

endmodule

// ===== test/tb_preemptive_priority_heap_scheduler.sv =====
// testbench for the priority heap scheduler: table-driven and random beats against a predictor
`timescale 1ns / 100ps

module tb_preemptive_priority_heap_scheduler;

  localparam int Depth    = 128;
  localparam int MaxCyc   = 2000000;
  localparam int NumRand  = 1170;

  typedef struct {
    logic [6:0]  id;
    logic [7:0]  prio;
    logic [15:0] remain;
    logic [15:0] burst;
    logic [15:0] arrival;
    logic        ran;
  } sched_task_t;

  // one row of the directed table; chk_fixed set where the result is typed in
  typedef struct {
    pphs_pkg::in_item_t  beat;
    logic                chk_fixed;
    pphs_pkg::out_item_t fixed_res;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  pphs_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  pphs_pkg::out_item_t out_data;

  sched_task_t         heap_q [Depth];
  int                  heap_len;
  logic [15:0]         now_time;
  pphs_pkg::out_item_t sched_expect_q[$];
  int                  mismatch_cnt;
  int                  cycle_cnt;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  dir_row_t            dir_rows[$];

  preemptive_priority_heap_scheduler i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // heap insert with strict sift-up
  function automatic void heap_push(sched_task_t t);
    int pos;
    int up;
    sched_task_t tmp;
    pos = heap_len;
    heap_q[pos] = t;
    heap_len++;
    while (pos != 0) begin
      up = (pos - 1) / 2;
      if (heap_q[up].prio > heap_q[pos].prio) begin
        tmp = heap_q[up];
        heap_q[up] = heap_q[pos];
        heap_q[pos] = tmp;
        pos = up;
      end else begin
        break;
      end
    end
  endfunction

  // sift-down from the root, left child tested first
  function automatic void heap_sift_down();
    int pos;
    int best;
    int l;
    int r;
    sched_task_t tmp;
    pos = 0;
    forever begin
      best = pos;
      l = 2 * pos + 1;
      r = 2 * pos + 2;
      if (l < heap_len && heap_q[l].prio < heap_q[best].prio) best = l;
      if (r < heap_len && heap_q[r].prio < heap_q[best].prio) best = r;
      if (best == pos) break;
      tmp = heap_q[best];
      heap_q[best] = heap_q[pos];
      heap_q[pos] = tmp;
      pos = best;
    end
  endfunction

  // schedule one accepted beat; queue its result if it gives one
  function automatic void schedule_beat(pphs_pkg::in_item_t b);
    sched_task_t t;
    pphs_pkg::out_item_t res;
    res = '0;
    if (b.opcode == pphs_pkg::OP_ARRIVAL) begin
      t.id = b.task_id;
      t.prio = b.task_priority;
      t.burst = (b.burst_length == 16'd0) ? 16'd1 : b.burst_length;
      t.remain = t.burst;
      t.arrival = now_time;
      t.ran = 1'b0;
      if (heap_len >= Depth) begin
        res.status = pphs_pkg::ST_DROPPED;
        res.ran_id = b.task_id;
        sched_expect_q.push_back(res);
      end else begin
        heap_push(t);
      end
      return;
    end
    res.status = pphs_pkg::ST_IDLE;
    if (heap_len != 0) begin
      t = heap_q[0];
      heap_len--;
      if (heap_len >= 1) begin
        heap_q[0] = heap_q[heap_len];
        heap_sift_down();
      end
      res.ran_id = t.id;
      if (!t.ran) begin
        t.ran = 1'b1;
        res.first_run = 1'b1;
        res.response_time = now_time - t.arrival;
      end
      t.remain--;
      if (t.remain != 0) begin
        res.status = pphs_pkg::ST_RAN;
        heap_push(t);
      end else begin
        res.status = pphs_pkg::ST_DONE;
        res.wait_time = now_time + 16'd1 - t.arrival - t.burst;
      end
    end
    sched_expect_q.push_back(res);
    now_time++;
  endfunction

  // drive one beat, holding valid until accepted; returns at the next falling edge
  task automatic send_beat(pphs_pkg::in_item_t b);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    schedule_beat(b);
    @(negedge clk);
  endtask

  // drop valid and wait until every expected result has come
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sched_expect_q.size() != 0) @(negedge clk);
  endtask

  function automatic pphs_pkg::in_item_t mk_beat(pphs_pkg::opcode_t op, int id, int prio,
                                                  int burst);
    pphs_pkg::in_item_t b;
    b.opcode = op;
    b.task_id = id[6:0];
    b.task_priority = prio[7:0];
    b.burst_length = burst[15:0];
    return b;
  endfunction

  function automatic void add_row(pphs_pkg::in_item_t b, logic fixed,
                                  pphs_pkg::out_item_t r);
    dir_row_t row;
    row.beat = b;
    row.chk_fixed = fixed;
    row.fixed_res = r;
    dir_rows.push_back(row);
  endfunction

  // random beat: arrivals with varied content, ticks weighted to keep heap moving
  function automatic pphs_pkg::in_item_t rand_beat(int tick_pct);
    pphs_pkg::in_item_t b;
    int sel;
    b.opcode = ($urandom_range(99, 0) < tick_pct) ? pphs_pkg::OP_TICK : pphs_pkg::OP_ARRIVAL;
    b.task_id = 7'($urandom_range(127, 0));
    b.task_priority = ($urandom_range(3, 0) == 0) ? 8'($urandom_range(3, 0))
                                                  : 8'($urandom_range(255, 0));
    sel = $urandom_range(9, 0);
    if (sel == 0) b.burst_length = 16'd0;
    else if (sel == 1) b.burst_length = 16'($urandom_range(65535, 0));
    else b.burst_length = 16'($urandom_range(4, 1));
    return b;
  endfunction

  // output check against the oldest expectation
  always @(posedge clk) begin
    pphs_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (sched_expect_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result beat %p", out_data);
      end else begin
        want = sched_expect_q.pop_front();
        if (out_data.status !== want.status || out_data.ran_id !== want.ran_id ||
            out_data.first_run !== want.first_run ||
            out_data.response_time !== want.response_time ||
            out_data.wait_time !== want.wait_time) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("result mismatch exp %p got %p", want, out_data);
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= !(recv_idle_pct != 0 && $urandom_range(99, 0) < recv_idle_pct);
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > MaxCyc) begin
      $display("preemptive_priority_heap_scheduler regression: fail");
      $finish;
    end
  end

  initial begin
    pphs_pkg::out_item_t r;
    int i;
    int k;
    int phase;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b1;
    heap_len = 0;
    now_time = '0;
    mismatch_cnt = 0;
    cycle_cnt = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table: empty tick, extremes, zero burst, equal priority, long burst
    r = '0;
    r.status = pphs_pkg::ST_IDLE;
    add_row(mk_beat(pphs_pkg::OP_TICK, 127, 255, 65535), 1'b1, r);
    add_row(mk_beat(pphs_pkg::OP_ARRIVAL, 0, 0, 0), 1'b0, r);
    r = '0;
    r.status = pphs_pkg::ST_DONE;
    r.first_run = 1'b1;
    add_row(mk_beat(pphs_pkg::OP_TICK, 0, 0, 0), 1'b1, r);
    add_row(mk_beat(pphs_pkg::OP_ARRIVAL, 127, 255, 65535), 1'b0, r);
    add_row(mk_beat(pphs_pkg::OP_ARRIVAL, 5, 10, 2), 1'b0, r);
    add_row(mk_beat(pphs_pkg::OP_ARRIVAL, 6, 10, 1), 1'b0, r);
    add_row(mk_beat(pphs_pkg::OP_ARRIVAL, 7, 3, 3), 1'b0, r);
    add_row(mk_beat(pphs_pkg::OP_ARRIVAL, 42, 170, 16'h5555), 1'b0, r);
    add_row(mk_beat(pphs_pkg::OP_ARRIVAL, 85, 85, 16'haaaa), 1'b0, r);
    for (i = 0; i < 10; i++) add_row(mk_beat(pphs_pkg::OP_TICK, 0, 0, 0), 1'b0, r);
    foreach (dir_rows[j]) begin
      send_beat(dir_rows[j].beat);
      if (dir_rows[j].chk_fixed &&
          sched_expect_q[sched_expect_q.size() - 1] !== dir_rows[j].fixed_res) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("table row %0d predicted wrong", j);
      end
    end
    // fill the heap to force drops, then pause until drained
    for (i = 0; i < Depth + 4; i++) send_beat(rand_beat(0));
    drain_results();
    for (i = 0; i < Depth + 4; i++) send_beat(mk_beat(pphs_pkg::OP_TICK, 0, 0, 0));
    drain_results();

    // random phases with changing stall mix
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 84 : 0;
      recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 6 : 0;
      for (k = 0; k < NumRand / 3; k++) send_beat(rand_beat(55));
      drain_results();
    end
    recv_idle_pct = 0;
    repeat (100) @(negedge clk);
    if (mismatch_cnt == 0 && sched_expect_q.size() == 0) begin
      $display("preemptive_priority_heap_scheduler regression: pass");
    end else begin
      $display("preemptive_priority_heap_scheduler regression: fail");
    end
    $finish;
  end

endmodule
